// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the strip chart sample plotter.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int COORD_W     = 10;
    localparam int PIXX_W      = 11;
    localparam int COL_W       = 8;
    localparam int CCNT_W      = 9;
    localparam int SCROLL_W    = 8;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STYLE_DOT  = 2'd0,
        STYLE_LINE = 2'd1,
        STYLE_FILL = 2'd2
    } t_style;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_BASE_Y    = 3'd1,
        REG_WIN_H     = 3'd2,
        REG_COL_CNT   = 3'd3,
        REG_CLIP_MIN  = 3'd4,
        REG_CLIP_MAX  = 3'd5,
        REG_STYLE     = 3'd6,
        REG_SCROLL    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_cmd                        cmd;
        logic signed [SAMPLE_W-1:0]  sample_value;
        logic [COL_W-1:0]            column_index;
    } t_in_item;

    typedef struct packed {
        logic [PIXX_W-1:0]  pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COORD_W-1:0] span_base_y;
        logic               draw_kind;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]         plot_origin_x;
        logic [COORD_W-1:0]         plot_base_y;
        logic [COORD_W-1:0]         window_height;
        logic [CCNT_W-1:0]          column_count;
        logic signed [SAMPLE_W-1:0] clip_min;
        logic signed [SAMPLE_W-1:0] clip_max;
        logic [1:0]                 plot_style;
        logic [SCROLL_W-1:0]        scroll_offset;
    } t_cfg;

endpackage

// ===== rtl/scp_cfg.sv =====
// ----------------------------------------------------------------------------
// scp_cfg
// APB register file holding the plot configuration.
// ----------------------------------------------------------------------------
module scp_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [scp_pkg::APB_AW-1:0] paddr,
    input  logic [scp_pkg::APB_DW-1:0] pwdata,
    output logic [scp_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output scp_pkg::t_cfg             o_cfg
);
    import scp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plot_origin_x <= '0;
            r_cfg.plot_base_y   <= '0;
            r_cfg.window_height <= COORD_W'(255);
            r_cfg.column_count  <= CCNT_W'(256);
            r_cfg.clip_min      <= '0;
            r_cfg.clip_max      <= SAMPLE_W'(255);
            r_cfg.plot_style    <= STYLE_DOT;
            r_cfg.scroll_offset <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X: r_cfg.plot_origin_x <= pwdata[COORD_W-1:0];
                REG_BASE_Y:   r_cfg.plot_base_y   <= pwdata[COORD_W-1:0];
                REG_WIN_H:    r_cfg.window_height <= pwdata[COORD_W-1:0];
                REG_COL_CNT:  r_cfg.column_count  <= pwdata[CCNT_W-1:0];
                REG_CLIP_MIN: r_cfg.clip_min      <= pwdata[SAMPLE_W-1:0];
                REG_CLIP_MAX: r_cfg.clip_max      <= pwdata[SAMPLE_W-1:0];
                REG_STYLE:    r_cfg.plot_style    <= pwdata[1:0];
                REG_SCROLL:   r_cfg.scroll_offset <= pwdata[SCROLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X: prdata = APB_DW'(r_cfg.plot_origin_x);
            REG_BASE_Y:   prdata = APB_DW'(r_cfg.plot_base_y);
            REG_WIN_H:    prdata = APB_DW'(r_cfg.window_height);
            REG_COL_CNT:  prdata = APB_DW'(r_cfg.column_count);
            REG_CLIP_MIN: prdata = APB_DW'(r_cfg.clip_min);
            REG_CLIP_MAX: prdata = APB_DW'(r_cfg.clip_max);
            REG_STYLE:    prdata = APB_DW'(r_cfg.plot_style);
            REG_SCROLL:   prdata = APB_DW'(r_cfg.scroll_offset);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/strip_chart_sample_plotter.sv =====
// A render transfer is registered in the read stage, then in the output register, which holds it while stalled.
// Throughput: one item per cycle unless o_in_stall is raised; add and render share the single store port pair.
// Adds give no result; renders outside the window or in line style or the unused style code give none.
// Reset is synchronous; per-entry valid bits make the store read as zero at once,
// so there is no clearing pass and items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// strip_chart_sample_plotter
// Ring store of samples with a scrolling plot window; renders one column per
// transfer as a dot or a vertical span.
// ----------------------------------------------------------------------------
module strip_chart_sample_plotter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  scp_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output scp_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::APB_AW-1:0] paddr,
    input  logic [scp_pkg::APB_DW-1:0] pwdata,
    output logic [scp_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import scp_pkg::*;

    localparam logic [CCNT_W-1:0] DEPTH_CC = CCNT_W'(STORE_DEPTH);

    t_cfg w_cfg;

    scp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]     r_vld;
    logic [PTR_W-1:0]           r_wp;

    logic                       r_s1_vld, n_s1_vld;
    logic [COL_W-1:0]           r_s1_col;
    logic signed [SAMPLE_W-1:0] r_s1_rd;
    logic                       r_s1_rd_vld;

    logic                       r_out_vld;
    t_out_item                  r_out;

    logic                       w_acc, w_add, w_rnd, w_scroll, w_hit, w_s1_adv;
    logic [PTR_W-1:0]           w_start, w_idx;
    logic signed [SAMPLE_W-1:0] w_v;
    logic [COORD_W-1:0]         w_off;
    t_out_item                  w_res;

    assign w_s1_adv   = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !w_s1_adv;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_add      = w_acc && (i_in_data.cmd == CMD_ADD);
    assign w_rnd      = w_acc && (i_in_data.cmd == CMD_RENDER);
    assign w_scroll   = w_cfg.column_count < DEPTH_CC;

    always_comb begin
        w_start = w_scroll ? r_wp + PTR_W'(w_cfg.scroll_offset)
                           : r_wp - PTR_W'(w_cfg.column_count);
        w_idx   = w_start + PTR_W'(i_in_data.column_index);
        w_hit   = (!w_scroll || (CCNT_W'(i_in_data.column_index) < w_cfg.column_count))
               && ((w_cfg.plot_style == STYLE_DOT) || (w_cfg.plot_style == STYLE_FILL));
    end

    always_comb begin
        if (r_s1_vld && !w_s1_adv) begin
            n_s1_vld = r_s1_vld;
        end else begin
            n_s1_vld = w_rnd && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add) begin
            mem[r_wp] <= i_in_data.sample_value;
        end
        if (w_acc) begin
            r_s1_rd     <= mem[w_idx];
            r_s1_rd_vld <= r_vld[w_idx];
            r_s1_col    <= i_in_data.column_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_wp     <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_add) begin
                r_vld[r_wp] <= 1'b1;
                r_wp        <= r_wp + PTR_W'(1);
            end
            r_s1_vld <= n_s1_vld;
        end
    end

    // clamp to clip range, then to 0..window_height
    always_comb begin
        w_v = r_s1_rd_vld ? r_s1_rd : '0;
        if (w_v > w_cfg.clip_max) begin
            w_v = w_cfg.clip_max;
        end else if (w_v < w_cfg.clip_min) begin
            w_v = w_cfg.clip_min;
        end
        if (w_v[SAMPLE_W-1]) begin
            w_off = '0;
        end else if (w_v > $signed({{(SAMPLE_W-COORD_W){1'b0}}, w_cfg.window_height})) begin
            w_off = w_cfg.window_height;
        end else begin
            w_off = w_v[COORD_W-1:0];
        end
        w_res.pixel_x     = PIXX_W'(w_cfg.plot_origin_x) + PIXX_W'(r_s1_col);
        w_res.pixel_y     = (w_cfg.plot_base_y >= w_off) ? w_cfg.plot_base_y - w_off : '0;
        w_res.span_base_y = w_cfg.plot_base_y;
        w_res.draw_kind   = (w_cfg.plot_style == STYLE_FILL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/scp_chk.sv =====
// ----------------------------------------------------------------------------
// scp_chk
// Port-level checks for the strip chart sample plotter.
// ----------------------------------------------------------------------------
module scp_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input scp_pkg::t_out_item  o_out_data
);
    import scp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pixel_y <= o_out_data.span_base_y)
        else $error("point lies below baseline");

endmodule

bind strip_chart_sample_plotter scp_chk u_scp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== sim/strip_chart_sample_plotter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strip_chart_sample_plotter_test
// Self-checking bench for the strip chart plotter. A shadow of the sample ring,
// write pointer and plot registers predicts each render transfer; results are
// checked in order against the prediction. Directed corner cases come first,
// then random add/render traffic under several idling and stall mixes, with
// register settings changed only while the block is drained.
// ----------------------------------------------------------------------------
module strip_chart_sample_plotter_test;

    import scp_pkg::*;

    localparam int           WATCHDOG_LIMIT = 3000;
    localparam int           SETTLE_CYCLES  = 8;
    localparam logic [1:0]   STYLE_UNUSED   = 2'd3;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            in_data   = '0;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;

    t_cfg                shadow_cfg;
    logic signed [SAMPLE_W-1:0] sample_ring [STORE_DEPTH];
    int unsigned         ring_wr_ptr;
    t_out_item           pending_pixels [$];

    strip_chart_sample_plotter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // predicted pixel for a render of one column; returns 0 when nothing is drawn
    function automatic bit plot_column(input logic [COL_W-1:0] col, output t_out_item px);
        int unsigned visible, start, slot, offset;
        int          v;
        px = '0;
        visible = (shadow_cfg.column_count < STORE_DEPTH) ? shadow_cfg.column_count
                                                          : STORE_DEPTH;
        if (col >= visible)
            return 0;
        if (shadow_cfg.plot_style != STYLE_DOT && shadow_cfg.plot_style != STYLE_FILL)
            return 0;
        if (shadow_cfg.column_count < STORE_DEPTH)
            start = (ring_wr_ptr + shadow_cfg.scroll_offset) % STORE_DEPTH;
        else
            start = (ring_wr_ptr + STORE_DEPTH - (shadow_cfg.column_count % STORE_DEPTH))
                    % STORE_DEPTH;
        slot = (start + col) % STORE_DEPTH;
        v = sample_ring[slot];
        if (v > $signed(shadow_cfg.clip_max))
            v = $signed(shadow_cfg.clip_max);
        else if (v < $signed(shadow_cfg.clip_min))
            v = $signed(shadow_cfg.clip_min);
        offset = (v >= 0) ? v : 0;
        if (offset > shadow_cfg.window_height)
            offset = shadow_cfg.window_height;
        px.pixel_x     = PIXX_W'(shadow_cfg.plot_origin_x) + PIXX_W'(col);
        px.pixel_y     = (shadow_cfg.plot_base_y >= offset)
                         ? COORD_W'(shadow_cfg.plot_base_y - offset) : '0;
        px.span_base_y = shadow_cfg.plot_base_y;
        px.draw_kind   = (shadow_cfg.plot_style == STYLE_FILL);
        return 1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual x %0d y %0d",
                         $time, o_out_data.pixel_x, o_out_data.pixel_y);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.pixel_x, o_out_data.pixel_x);
                check_field("pixel_y", want.pixel_y, o_out_data.pixel_y);
                check_field("span_base_y", want.span_base_y, o_out_data.span_base_y);
                check_field("draw_kind", want.draw_kind, o_out_data.draw_kind);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_X: shadow_cfg.plot_origin_x = value[COORD_W-1:0];
            REG_BASE_Y:   shadow_cfg.plot_base_y   = value[COORD_W-1:0];
            REG_WIN_H:    shadow_cfg.window_height = value[COORD_W-1:0];
            REG_COL_CNT:  shadow_cfg.column_count  = value[CCNT_W-1:0];
            REG_CLIP_MIN: shadow_cfg.clip_min      = value[SAMPLE_W-1:0];
            REG_CLIP_MAX: shadow_cfg.clip_max      = value[SAMPLE_W-1:0];
            REG_STYLE:    shadow_cfg.plot_style    = value[1:0];
            REG_SCROLL:   shadow_cfg.scroll_offset = value[SCROLL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item item);
        t_out_item px;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (item.cmd == CMD_ADD) begin
            sample_ring[ring_wr_ptr] = item.sample_value;
            ring_wr_ptr = (ring_wr_ptr + 1) % STORE_DEPTH;
        end else if (plot_column(item.column_index, px)) begin
            pending_pixels.push_back(px);
        end
    endtask

    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] v);
        t_in_item item;
        item.cmd          = CMD_ADD;
        item.sample_value = v;
        item.column_index = COL_W'($urandom);
        send_item(item);
    endtask

    task automatic render(input logic [COL_W-1:0] col);
        t_in_item item;
        item.cmd          = CMD_RENDER;
        item.sample_value = SAMPLE_W'($urandom);
        item.column_index = col;
        send_item(item);
    endtask

    function automatic int pick_extreme(input int top);
        case ($urandom_range(3))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    function automatic t_in_item make_random_item();
        t_in_item item;
        int       visible, lo, hi;
        item.sample_value = SAMPLE_W'($urandom);
        item.column_index = COL_W'($urandom);
        if ($urandom_range(1)) begin
            item.cmd = CMD_RENDER;
            visible = (shadow_cfg.column_count < STORE_DEPTH) ? shadow_cfg.column_count
                                                              : STORE_DEPTH;
            if ($urandom_range(4) != 0 && visible > 0)
                item.column_index = COL_W'($urandom_range(visible - 1));
        end else begin
            item.cmd = CMD_ADD;
            lo = $signed(shadow_cfg.clip_min);
            hi = $signed(shadow_cfg.clip_max);
            if (lo > hi) begin
                lo = $signed(shadow_cfg.clip_max);
                hi = $signed(shadow_cfg.clip_min);
            end
            case ($urandom_range(9))
                0, 1, 2: ;
                3:       item.sample_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                4:       item.sample_value = SAMPLE_W'(int'($urandom_range(1100)) - 50);
                default: item.sample_value =
                             SAMPLE_W'(lo - 20 + int'($urandom_range(hi - lo + 40)));
            endcase
        end
        return item;
    endfunction

    task automatic randomise_plot_config();
        int         cc, lo, hi;
        logic [1:0] style;
        case ($urandom_range(3))
            0:       cc = 1;
            1:       cc = STORE_DEPTH;
            default: cc = 1 + $urandom_range(STORE_DEPTH - 1);
        endcase
        case ($urandom_range(6))
            0:       begin lo = -32768; hi = 32767; end
            1:       begin
                         hi = int'($urandom_range(600)) - 300;
                         lo = hi + 1 + int'($urandom_range(400));
                     end
            default: begin
                         lo = int'($urandom_range(600)) - 300;
                         hi = lo + int'($urandom_range(1200));
                     end
        endcase
        case ($urandom_range(19))
            0:                 style = STYLE_LINE;
            1:                 style = STYLE_UNUSED;
            2, 3, 4, 5, 6, 7:  style = STYLE_DOT;
            default:           style = STYLE_FILL;
        endcase
        write_reg(REG_ORIGIN_X, pick_extreme(1023));
        write_reg(REG_BASE_Y, pick_extreme(1023));
        write_reg(REG_WIN_H, pick_extreme(1023));
        write_reg(REG_COL_CNT, cc);
        write_reg(REG_CLIP_MIN, lo);
        write_reg(REG_CLIP_MAX, hi);
        write_reg(REG_STYLE, APB_DW'(style));
        write_reg(REG_SCROLL, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                       : $urandom_range(STORE_DEPTH - cc));
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset settings, empty store
        render(0);
        render(255);
        add_sample(16'sh7FFF);
        add_sample(16'sh8000);
        add_sample(16'sh0000);
        add_sample(-16'sd1);
        add_sample(16'sd255);
        add_sample(16'sd1023);
        render(250);
        render(255);
        // full clip range, tall window, baseline saturation, fill spans
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_ORIGIN_X, 1023);
        write_reg(REG_BASE_Y, 100);
        write_reg(REG_WIN_H, 1023);
        write_reg(REG_CLIP_MIN, -32768);
        write_reg(REG_CLIP_MAX, 32767);
        write_reg(REG_STYLE, STYLE_FILL);
        render(250);
        render(251);
        render(255);
        // scrolled window past its range, inverted clip, window edge
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_BASE_Y, 1023);
        write_reg(REG_COL_CNT, 16);
        write_reg(REG_SCROLL, 250);
        write_reg(REG_CLIP_MIN, 100);
        write_reg(REG_CLIP_MAX, -100);
        write_reg(REG_STYLE, STYLE_DOT);
        render(0);
        render(1);
        render(15);
        render(16);
        render(255);
        // styles that draw nothing
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_STYLE, STYLE_LINE);
        render(0);
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_STYLE, STYLE_UNUSED);
        render(0);
        // single column, zero height; then one short of the store depth
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_STYLE, STYLE_DOT);
        write_reg(REG_COL_CNT, 1);
        write_reg(REG_WIN_H, 0);
        write_reg(REG_SCROLL, 0);
        add_sample(16'sh5555);
        add_sample(16'shAAAA);
        render(0);
        render(1);
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_COL_CNT, STORE_DEPTH - 1);
        write_reg(REG_SCROLL, 1);
        write_reg(REG_WIN_H, 1023);
        render(254);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int chunks, input int items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (chunks) begin
            wait_for_results(SETTLE_CYCLES);
            randomise_plot_config();
            repeat (items) send_item(make_random_item());
        end
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        wait_for_results(SETTLE_CYCLES);
        write_reg(REG_STYLE, STYLE_FILL);
        write_reg(REG_COL_CNT, 1 + $urandom_range(STORE_DEPTH - 1));
        repeat (40) send_item(make_random_item());
        wait_for_results(1);
        repeat (40) send_item(make_random_item());
    endtask

    initial begin
        shadow_cfg.plot_origin_x = 0;
        shadow_cfg.plot_base_y   = 0;
        shadow_cfg.window_height = 255;
        shadow_cfg.column_count  = CCNT_W'(STORE_DEPTH);
        shadow_cfg.clip_min      = 0;
        shadow_cfg.clip_max      = 255;
        shadow_cfg.plot_style    = STYLE_DOT;
        shadow_cfg.scroll_offset = 0;
        foreach (sample_ring[i]) sample_ring[i] = '0;
        ring_wr_ptr = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(0, 0, 4, 80);
        test_random_traffic(63, 0, 4, 80);
        test_random_traffic(0, 63, 4, 80);
        test_random_traffic(38, 38, 3, 80);
        test_pause_until_drained();

        wait_for_results(SETTLE_CYCLES);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
